/* hdl/sha1sh_pkg.sv */
package sha1sh_pkg;

    localparam int LENGTH_COUNTER_WIDTH = 64;
    localparam int HASH_WORDS = 5;
    localparam int SCHED_WORDS = 16;
    localparam int BYTE_POS_W = 6;
    localparam int ROUND_CNT_W = 7;
    localparam int WORD_IDX_W = 3;
    localparam int LEN_IDX_W = 3;

    localparam logic [BYTE_POS_W-1:0] LAST_POS = 6'd63;
    localparam logic [BYTE_POS_W-1:0] LEN_POS = 6'd56;
    localparam logic [ROUND_CNT_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [ROUND_CNT_W-1:0] GRP1_START = 7'd20;
    localparam logic [ROUND_CNT_W-1:0] GRP2_START = 7'd40;
    localparam logic [ROUND_CNT_W-1:0] GRP3_START = 7'd60;
    localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = 3'd4;
    localparam logic [LEN_IDX_W-1:0] LAST_LEN_IDX = 3'd7;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef logic [31:0] word_t;
    typedef logic [HASH_WORDS-1:0][31:0] chain_t;

    localparam chain_t INIT_CHAIN = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

    localparam word_t K_GRP0 = 32'h5A827999;
    localparam word_t K_GRP1 = 32'h6ED9EBA1;
    localparam word_t K_GRP2 = 32'h8F1BBCDC;
    localparam word_t K_GRP3 = 32'hCA62C1D6;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } dig_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_DATA,
        PH_WIDE,
        PH_PAD80,
        PH_PADZ,
        PH_LEN,
        PH_DONE,
        PH_OUT
    } phase_t;

    typedef enum logic [1:0] {
        RG_CH,
        RG_PAR1,
        RG_MAJ,
        RG_PAR2
    } round_grp_t;

    typedef struct packed {
        logic       init;
        logic       load;
        logic       step;
        logic       add;
        round_grp_t grp;
    } rnd_ctl_t;

    typedef struct packed {
        logic       shift_byte;
        logic       shift_round;
        logic [7:0] byte_in;
    } sched_ctl_t;

endpackage

/* hdl/sha1sh_sched.sv */
module sha1sh_sched (
    input  logic                    clk,
    input  sha1sh_pkg::sched_ctl_t  ctl,
    output sha1sh_pkg::word_t       w
);
    import sha1sh_pkg::*;

    word_t win_reg  [SCHED_WORDS];
    word_t win_next [SCHED_WORDS];
    word_t mix;

    // window holds w[t..t+15]; byte loading shifts the 512-bit line left by one byte
    always_comb
    begin
        mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        for (int i = 0; i < SCHED_WORDS; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctl.shift_byte)
        begin
            for (int i = 0; i < SCHED_WORDS - 1; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[SCHED_WORDS-1] = {win_reg[SCHED_WORDS-1][23:0], ctl.byte_in};
        end
        else if (ctl.shift_round)
        begin
            for (int i = 0; i < SCHED_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[SCHED_WORDS-1] = {mix[30:0], mix[31]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SCHED_WORDS; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    assign w = win_reg[0];

endmodule

/* hdl/sha1sh_round.sv */
module sha1sh_round (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha1sh_pkg::rnd_ctl_t  ctl,
    input  sha1sh_pkg::word_t     w,
    output sha1sh_pkg::chain_t    chain
);
    import sha1sh_pkg::*;

    chain_t work_reg;
    chain_t work_next;
    chain_t chain_reg;
    chain_t chain_next;
    word_t  a, b, c, d, e;
    word_t  f, k, t;

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];

    always_comb
    begin
        unique case (ctl.grp)
            RG_CH:
            begin
                f = (b & c) | (~b & d);
                k = K_GRP0;
            end
            RG_PAR1:
            begin
                f = b ^ c ^ d;
                k = K_GRP1;
            end
            RG_MAJ:
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_GRP2;
            end
            RG_PAR2:
            begin
                f = b ^ c ^ d;
                k = K_GRP3;
            end
            default:
            begin
                f = b ^ c ^ d;
                k = K_GRP3;
            end
        endcase
        t = {a[26:0], a[31:27]} + f + e + k + w;
    end

    always_comb
    begin
        work_next = work_reg;
        if (ctl.load)
        begin
            work_next = chain_reg;
        end
        else if (ctl.step)
        begin
            work_next[0] = t;
            work_next[1] = a;
            work_next[2] = {b[1:0], b[31:2]};
            work_next[3] = c;
            work_next[4] = d;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (ctl.init)
        begin
            chain_next = INIT_CHAIN;
        end
        else if (ctl.add)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_CHAIN;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

/* hdl/sha1sh_ctrl.sv */
module sha1sh_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                msg_valid,
    output logic                                msg_ready,
    input  sha1sh_pkg::msg_item_t               msg_item,
    output logic                                dig_valid,
    input  logic                                dig_ready,
    input  logic                                cfg_valid,
    input  logic                                cfg_data,
    output logic                                mode,
    output logic [sha1sh_pkg::WORD_IDX_W-1:0]   word_idx,
    output sha1sh_pkg::sched_ctl_t              sched_ctl,
    output sha1sh_pkg::rnd_ctl_t                rnd_ctl
);
    import sha1sh_pkg::*;

    state_t                          state_reg, state_next;
    phase_t                          phase_reg, phase_next, phase_after;
    logic [BYTE_POS_W-1:0]           pos_reg, pos_next;
    logic [LENGTH_COUNTER_WIDTH-1:0] count_reg, count_next;
    logic [ROUND_CNT_W-1:0]          round_reg, round_next;
    logic [LEN_IDX_W-1:0]            len_idx_reg, len_idx_next;
    logic [WORD_IDX_W-1:0]           word_reg, word_next;
    logic                            mode_reg, mode_next;
    logic                            eom_reg, eom_next;
    logic [7:0]                      data_reg, data_next;
    logic [7:0]                      conv_byte;
    logic [7:0]                      feed_byte;
    logic [63:0]                     len_full;
    logic                            msg_xfer, dig_xfer, block_full, digest_done;

    function automatic state_t dispatch(phase_t p);
        state_t s;
        unique case (p)
            PH_DONE: s = ST_IDLE;
            PH_OUT:  s = ST_OUT;
            default: s = ST_FEED;
        endcase
        return s;
    endfunction

    assign msg_xfer    = msg_valid && msg_ready;
    assign dig_xfer    = dig_valid && dig_ready;
    assign block_full  = (state_reg == ST_FEED) && (pos_reg == LAST_POS);
    assign digest_done = dig_xfer && (word_reg == LAST_WORD_IDX);
    assign len_full    = 64'(count_reg);

    always_comb
    begin
        conv_byte = msg_item.data_byte;
        if (mode_reg && msg_item.data_byte >= CH_LOWER_A && msg_item.data_byte <= CH_LOWER_Z)
        begin
            conv_byte = msg_item.data_byte - CASE_OFFSET;
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_DATA:  feed_byte = data_reg;
            PH_PAD80: feed_byte = PAD_BYTE;
            PH_LEN:   feed_byte = len_full[{~len_idx_reg, 3'b000} +: 8];
            default:  feed_byte = ZERO_BYTE;
        endcase
    end

    // where the byte sequence goes after the byte placed this cycle
    always_comb
    begin
        unique case (phase_reg)
            PH_DATA:
            begin
                priority if (mode_reg)
                    phase_after = PH_WIDE;
                else if (eom_reg)
                    phase_after = PH_PAD80;
                else
                    phase_after = PH_DONE;
            end
            PH_WIDE:
                phase_after = eom_reg ? PH_PAD80 : PH_DONE;
            PH_PAD80, PH_PADZ:
                phase_after = (pos_reg + 1'b1 == LEN_POS) ? PH_LEN : PH_PADZ;
            PH_LEN:
                phase_after = (len_idx_reg == LAST_LEN_IDX) ? PH_OUT : PH_LEN;
            default:
                phase_after = phase_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_xfer && (msg_item.has_byte || msg_item.end_of_message))
                    state_next = ST_FEED;
            end
            ST_FEED:
            begin
                state_next = block_full ? ST_ROUND : dispatch(phase_after);
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = dispatch(phase_reg);
            end
            ST_OUT:
            begin
                if (digest_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath registers and counters
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        round_next   = round_reg;
        len_idx_next = len_idx_reg;
        word_next    = word_reg;
        eom_next     = eom_reg;
        data_next    = data_reg;
        mode_next    = cfg_valid ? cfg_data : mode_reg;
        if (msg_xfer)
        begin
            data_next  = conv_byte;
            eom_next   = msg_item.end_of_message;
            phase_next = msg_item.has_byte ? PH_DATA : PH_PAD80;
        end
        if (state_reg == ST_FEED)
        begin
            phase_next = phase_after;
            pos_next   = pos_reg + 1'b1;
            if (phase_reg == PH_DATA || phase_reg == PH_WIDE)
                count_next = count_reg + LENGTH_COUNTER_WIDTH'(8);
            if (phase_reg == PH_LEN)
                len_idx_next = len_idx_reg + 1'b1;
        end
        if (block_full)
            round_next = '0;
        else if (state_reg == ST_ROUND)
            round_next = round_reg + 1'b1;
        if (dig_xfer)
            word_next = word_reg + 1'b1;
        if (digest_done)
        begin
            word_next  = '0;
            count_next = '0;
        end
    end

    // outputs
    always_comb
    begin
        msg_ready             = (state_reg == ST_IDLE);
        dig_valid             = (state_reg == ST_OUT);
        sched_ctl.shift_byte  = (state_reg == ST_FEED);
        sched_ctl.shift_round = (state_reg == ST_ROUND);
        sched_ctl.byte_in     = feed_byte;
        rnd_ctl.init          = digest_done;
        rnd_ctl.load          = block_full;
        rnd_ctl.step          = (state_reg == ST_ROUND);
        rnd_ctl.add           = (state_reg == ST_ADD);
        priority if (round_reg < GRP1_START)
            rnd_ctl.grp = RG_CH;
        else if (round_reg < GRP2_START)
            rnd_ctl.grp = RG_PAR1;
        else if (round_reg < GRP3_START)
            rnd_ctl.grp = RG_MAJ;
        else
            rnd_ctl.grp = RG_PAR2;
    end

    assign mode     = mode_reg;
    assign word_idx = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_DONE;
            pos_reg     <= '0;
            count_reg   <= '0;
            round_reg   <= '0;
            len_idx_reg <= '0;
            word_reg    <= '0;
            mode_reg    <= 1'b0;
            eom_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            round_reg   <= round_next;
            len_idx_reg <= len_idx_next;
            word_reg    <= word_next;
            mode_reg    <= mode_next;
            eom_reg     <= eom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // compression only ever starts on a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (pos_reg == '0))
        else $error("round phase with partial block");

    // padding always finishes a block and the whole length field
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (pos_reg == '0 && len_idx_reg == '0))
        else $error("digest out before padding complete");

    // digest output is only entered from the final chaining add, starting at word 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && $past(state_reg) != ST_OUT)
            |-> ($past(state_reg) == ST_ADD && word_reg == '0))
        else $error("digest out entered from wrong state");

    // bit count only grows in whole bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[2:0] == 3'b000))
        else $error("bit count not byte aligned");

endmodule

/* hdl/sha1_stream_hasher_core.sv */
// SHA-1 over a byte stream, one message byte per msg transfer, digest out as five 32-bit
// words (h0 first) on the dig channel after the transfer that carries end_of_message.
// A byte item is transferred and then fed in as one byte (as two in service-name mode,
// where the byte is upper-cased and followed by a zero byte and the words come out
// byte-reversed). Every completed 64-byte block runs 80 rounds through the one
// shared round unit, one per cycle, then a chaining add. The end item feeds one padding or
// length byte per cycle (9 to 72) plus the blocks those bytes complete, then the five words.
// The block takes no new item until the digest has been fully transferred; it then
// starts a new message. The mode register may be written at any time the block is idle.
module sha1_stream_hasher_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_ready,
    input  sha1sh_pkg::msg_item_t  msg_item,
    output logic                   dig_valid,
    input  logic                   dig_ready,
    output sha1sh_pkg::dig_item_t  dig_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);
    import sha1sh_pkg::*;

    sched_ctl_t              sched_ctl;
    rnd_ctl_t                rnd_ctl;
    word_t                   w;
    chain_t                  chain;
    logic                    mode;
    logic [WORD_IDX_W-1:0]   word_idx;
    word_t                   sel_word;

    sha1sh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg_item  (msg_item),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .word_idx  (word_idx),
        .sched_ctl (sched_ctl),
        .rnd_ctl   (rnd_ctl)
    );

    sha1sh_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .w   (w)
    );

    sha1sh_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rnd_ctl),
        .w     (w),
        .chain (chain)
    );

    assign cfg_ready = 1'b1;
    assign sel_word  = chain[word_idx];

    always_comb
    begin
        dig_item.digest_word = mode ? {sel_word[7:0], sel_word[15:8], sel_word[23:16],
                                       sel_word[31:24]}
                                    : sel_word;
        dig_item.word_number = word_idx;
        dig_item.last_word   = (word_idx == LAST_WORD_IDX);
    end

endmodule
